// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, skipped while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a condition never holds on a rising clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

// File: design/wsd_pkg.sv
// ---------------------------------------------------------------------------
// WebSocket deframer package
// Shared types, event codes and header constants.
// ---------------------------------------------------------------------------
package wsd_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int LEN_W  = 32;

    // Event kinds carried on the result tuser
    localparam logic [KIND_W-1:0] KIND_DATA   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OPCODE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LENGTH = 3'd4;

    // Opcodes and length codes
    localparam logic [3:0] OPC_TEXT    = 4'h1;
    localparam logic [3:0] OPC_CLOSE   = 4'h8;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;

    // Header byte totals, mask key included
    localparam logic [3:0] HDR_SHORT   = 4'd6;
    localparam logic [3:0] HDR_MID     = 4'd8;
    localparam logic [3:0] HDR_LONG    = 4'd14;
    localparam logic [3:0] KEY_BYTES   = 4'd4;
    localparam logic [3:0] UPPER_END   = 4'd6;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_EXT     = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_HALT    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } result_t;

    function automatic logic [3:0] hdr_total(input logic [6:0] len_code);
        logic [3:0] tot;
        if (len_code < LEN_EXT16)
            tot = HDR_SHORT;
        else if (len_code == LEN_EXT16)
            tot = HDR_MID;
        else
            tot = HDR_LONG;
        return tot;
    endfunction

endpackage

// File: design/websocket_frame_deframer.sv
// ---------------------------------------------------------------------------
// WebSocket frame deframer
// Parses client-to-server frames a byte at a time and unmasks the payload.
// ---------------------------------------------------------------------------
// Input channel s_axis: one received stream byte per beat.
// Output channel m_axis: one event per beat. tuser carries the kind (payload
// byte, empty message, close, wrong opcode, bad length), tdata the unmasked
// payload byte (zero for other kinds), tlast the final byte of a frame or an
// empty message.
// Header, length and key bytes that decide nothing produce no output beat.
// An event reaches m_axis from the result register, via the skid entry on a stall.
// Throughput: one byte per cycle while s_axis_tready is high; all decode and unmask
// work for a byte sits between the frame state registers and the result register.
// Reset clears the frame state to the start of a header and empties the
// output. After a close, wrong opcode or bad length event, input bytes are
// still taken but dropped until the next reset.
// When m_axis stalls, one further result is held in a skid entry; s_axis
// drops tready only while that entry is occupied.
// ---------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic [2:0] m_axis_tuser,   // [2:0] kind
    output logic       m_axis_tlast    // last_of_message
);
    import wsd_pkg::*;

    result_t result;
    logic    beat_en;

    assign beat_en = s_axis_tvalid && s_axis_tready;

    wsd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat_en (beat_en),
        .rx_byte (s_axis_tdata),
        .result  (result)
    );

    wsd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// File: design/wsd_parser.sv
// ---------------------------------------------------------------------------
// WebSocket deframer parser
// Frame state registers and the per-beat decode, unmask and event logic.
// ---------------------------------------------------------------------------
module wsd_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   beat_en,
    input  logic [7:0]             rx_byte,
    output wsd_pkg::result_t       result
);
    import wsd_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic [3:0]  hdr_cnt_reg,  hdr_cnt_next;
    logic [3:0]  opcode_reg,   opcode_next;
    logic [6:0]  len_code_reg, len_code_next;
    logic        upper_nz_reg, upper_nz_next;
    logic [31:0] remain_reg,   remain_next;
    logic [31:0] key_reg,      key_next;
    logic [1:0]  key_idx_reg,  key_idx_next;

    logic [3:0]  total;
    logic [3:0]  pos_inc;
    logic [7:0]  key_byte;

    assign total    = hdr_total(len_code_reg);
    assign pos_inc  = hdr_cnt_reg + 4'd1;
    // key byte 0 sits in the top byte, so shift by (3 - index) bytes
    assign key_byte = 8'(key_reg >> {~key_idx_reg, 3'b000});

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        opcode_next   = opcode_reg;
        len_code_next = len_code_reg;
        upper_nz_next = upper_nz_reg;
        remain_next   = remain_reg;
        key_next      = key_reg;
        key_idx_next  = key_idx_reg;
        result        = '0;
        if (beat_en)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_cnt_reg == 4'd0)
                    begin
                        opcode_next  = rx_byte[3:0];
                        hdr_cnt_next = 4'd1;
                    end
                    else
                    begin
                        len_code_next = rx_byte[6:0];
                        hdr_cnt_next  = 4'd2;
                        if (opcode_reg == OPC_CLOSE)
                        begin
                            phase_next   = PH_HALT;
                            result.valid = 1'b1;
                            result.kind  = KIND_CLOSE;
                        end
                        else if (opcode_reg != OPC_TEXT)
                        begin
                            phase_next   = PH_HALT;
                            result.valid = 1'b1;
                            result.kind  = KIND_OPCODE;
                        end
                        else
                        begin
                            upper_nz_next = 1'b0;
                            remain_next   = (rx_byte[6:0] < LEN_EXT16) ?
                                            32'(rx_byte[6:0]) : 32'd0;
                            key_next      = '0;
                            phase_next    = PH_EXT;
                        end
                    end
                end
                PH_EXT:
                begin
                    if (hdr_cnt_reg >= total - KEY_BYTES)
                        key_next = {key_reg[23:0], rx_byte};
                    else if (len_code_reg == LEN_EXT64 && hdr_cnt_reg < UPPER_END)
                        upper_nz_next = upper_nz_reg | (rx_byte != 8'd0);
                    else
                        remain_next = {remain_reg[23:0], rx_byte};
                    hdr_cnt_next = pos_inc;
                    if (pos_inc >= total)
                    begin
                        key_idx_next = 2'd0;
                        if (upper_nz_next)
                        begin
                            phase_next   = PH_HALT;
                            result.valid = 1'b1;
                            result.kind  = KIND_LENGTH;
                        end
                        else
                        begin
                            hdr_cnt_next = 4'd0;
                            if (remain_next == 32'd0)
                            begin
                                phase_next   = PH_HEADER;
                                result.valid = 1'b1;
                                result.kind  = KIND_EMPTY;
                                result.last  = 1'b1;
                            end
                            else
                                phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    key_idx_next = key_idx_reg + 2'd1;
                    remain_next  = remain_reg - 32'd1;
                    result.valid = 1'b1;
                    result.kind  = KIND_DATA;
                    result.data  = rx_byte ^ key_byte;
                    if (remain_reg == 32'd1)
                    begin
                        result.last  = 1'b1;
                        phase_next   = PH_HEADER;
                        hdr_cnt_next = 4'd0;
                    end
                end
                PH_HALT:
                begin
                    // drop everything until reset
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hdr_cnt_reg  <= '0;
            opcode_reg   <= '0;
            len_code_reg <= '0;
            upper_nz_reg <= 1'b0;
            remain_reg   <= '0;
            key_reg      <= '0;
            key_idx_reg  <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            opcode_reg   <= opcode_next;
            len_code_reg <= len_code_next;
            upper_nz_reg <= upper_nz_next;
            remain_reg   <= remain_next;
            key_reg      <= key_next;
            key_idx_reg  <= key_idx_next;
        end
    end

endmodule

// File: design/wsd_out_stage.sv
// ---------------------------------------------------------------------------
// WebSocket deframer output stage
// Result register with a skid entry so the input side keeps flowing.
// ---------------------------------------------------------------------------
module wsd_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wsd_pkg::result_t       result,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             out_kind,
    output logic [7:0]             out_data,
    output logic                   out_last
);
    import wsd_pkg::*;

    result_t out_reg,  out_next;
    result_t skid_reg, skid_next;

    assign in_ready  = !skid_reg.valid;
    assign out_valid = out_reg.valid;
    assign out_kind  = out_reg.kind;
    assign out_data  = out_reg.data;
    assign out_last  = out_reg.last;

    always_comb
    begin
        out_next  = out_reg;
        skid_next = skid_reg;
        if (!out_reg.valid || out_ready)
        begin
            // advance: skid entry first, else the fresh result
            if (skid_reg.valid)
            begin
                out_next        = skid_reg;
                skid_next.valid = 1'b0;
            end
            else
                out_next = result;
        end
        else if (result.valid)
            skid_next = result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else
        begin
            out_reg  <= out_next;
            skid_reg <= skid_next;
        end
    end

endmodule

// File: design/wsd_checker.sv
// ---------------------------------------------------------------------------
// WebSocket deframer checker
// Port-level assertions on the output event stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);
    import wsd_pkg::*;

    logic halt_evt;
    logic out_beat;
    logic in_beat;

    assign out_beat = m_axis_tvalid && m_axis_tready;
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign halt_evt = m_axis_tuser == KIND_CLOSE || m_axis_tuser == KIND_OPCODE ||
                      m_axis_tuser == KIND_LENGTH;

    `ASSERT_CLK(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid,
        "m_axis beat dropped while stalled")
    `ASSERT_NEVER(a_event_data, m_axis_tvalid && m_axis_tuser != KIND_DATA &&
        m_axis_tdata != 8'd0, "event beat carries nonzero data")
    `ASSERT_NEVER(a_halt_last, m_axis_tvalid && halt_evt && m_axis_tlast,
        "halting event marked last")
    `ASSERT_CLK(a_halt_final, out_beat && halt_evt |=> !m_axis_tvalid,
        "output beat after a halting event")
    `ASSERT_CLK(a_idle_empty, !m_axis_tvalid && !in_beat |=> !m_axis_tvalid,
        "output beat without an input byte")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// WebSocket deframer testbench
// Feeds client frames byte by byte and checks every event beat against an
// in-bench frame parser. Both stream sides idle at random. The run ends with
// one halting event (close, wrong opcode or bad length), because only reset
// leaves the halted state.
// ---------------------------------------------------------------------------
module tb;
    import wsd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 1300;
    localparam int HOLDOFF_CYC  = 150;

    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_MID,
        FORM_LONG
    } len_form_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        data;
        logic              last;
    } ws_event_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    websocket_frame_deframer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Parser state mirrored from the frame format
    phase_t      frm_phase;
    logic [3:0]  frm_hdr_cnt;
    logic [3:0]  frm_opcode;
    logic [6:0]  frm_len_code;
    logic        frm_upper_nz;
    logic [31:0] frm_remain;
    logic [31:0] frm_key;
    logic [1:0]  frm_key_idx;

    ws_event_t   pending_events[$];
    ws_event_t   want;
    int          fail_cnt;
    int          cycle_cnt;
    int          bytes_sent;
    bit          src_idle_en;
    bit          snk_idle_en;
    int          snk_wait;
    int          hold_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic push_event(input logic [KIND_W-1:0] kind, input logic [7:0] data,
                              input logic last);
        ws_event_t ev;
        ev.kind = kind;
        ev.data = data;
        ev.last = last;
        pending_events.push_back(ev);
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic [3:0] total;
        logic [3:0] pos;
        logic [7:0] kb;
        case (frm_phase)
            PH_HALT: ;
            PH_HEADER:
            begin
                if (frm_hdr_cnt == 4'd0)
                begin
                    frm_opcode  = b[3:0];
                    frm_hdr_cnt = 4'd1;
                end
                else
                begin
                    frm_len_code = b[6:0];
                    frm_hdr_cnt  = 4'd2;
                    if (frm_opcode == OPC_CLOSE)
                    begin
                        frm_phase = PH_HALT;
                        push_event(KIND_CLOSE, 8'h00, 1'b0);
                    end
                    else if (frm_opcode != OPC_TEXT)
                    begin
                        frm_phase = PH_HALT;
                        push_event(KIND_OPCODE, 8'h00, 1'b0);
                    end
                    else
                    begin
                        frm_upper_nz = 1'b0;
                        frm_remain   = (frm_len_code < LEN_EXT16) ? {25'd0, frm_len_code} : 32'd0;
                        frm_key      = 32'd0;
                        frm_phase    = PH_EXT;
                    end
                end
            end
            PH_EXT:
            begin
                total = (frm_len_code < LEN_EXT16) ? HDR_SHORT :
                        (frm_len_code == LEN_EXT16) ? HDR_MID : HDR_LONG;
                pos = frm_hdr_cnt;
                if (pos >= total - KEY_BYTES)
                    frm_key = {frm_key[23:0], b};
                else if (frm_len_code == LEN_EXT64 && pos < UPPER_END)
                begin
                    if (b != 8'd0)
                        frm_upper_nz = 1'b1;
                end
                else
                    frm_remain = {frm_remain[23:0], b};
                frm_hdr_cnt = pos + 4'd1;
                if (frm_hdr_cnt == total)
                begin
                    frm_key_idx = 2'd0;
                    if (frm_upper_nz)
                    begin
                        frm_phase = PH_HALT;
                        push_event(KIND_LENGTH, 8'h00, 1'b0);
                    end
                    else
                    begin
                        frm_hdr_cnt = 4'd0;
                        if (frm_remain == 32'd0)
                        begin
                            frm_phase = PH_HEADER;
                            push_event(KIND_EMPTY, 8'h00, 1'b1);
                        end
                        else
                            frm_phase = PH_PAYLOAD;
                    end
                end
            end
            default:
            begin
                // first key byte sits in the top bits
                kb          = frm_key[8*(3-frm_key_idx) +: 8];
                frm_key_idx = frm_key_idx + 2'd1;
                frm_remain  = frm_remain - 32'd1;
                if (frm_remain == 32'd0)
                begin
                    frm_phase   = PH_HEADER;
                    frm_hdr_cnt = 4'd0;
                end
                push_event(KIND_DATA, b ^ kb, frm_remain == 32'd0);
            end
        endcase
    endtask

    // Check output beats first, then record the input beat of this edge
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected beat: kind %0d data %02h last %0d",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                fail_cnt++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (m_axis_tuser !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
                    fail_cnt++;
                end
                if (m_axis_tdata !== want.data)
                begin
                    $error("payload_byte: expected %02h, actual %02h", want.data, m_axis_tdata);
                    fail_cnt++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_of_message: expected %0d, actual %0d", want.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
        if (s_axis_tvalid && s_axis_tready)
            predict_byte(s_axis_tdata);
    end

    // Result side: random stalls after each beat, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            snk_wait = snk_idle_en ? $urandom_range(0, 4) : 0;
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (snk_wait > 0)
        begin
            snk_wait--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    // Drop valid and hold until every expected event has been seen
    task automatic wait_events_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_text_frame(input int unsigned plen, input len_form_t form,
                                   input logic [31:0] key, input bit extremes);
        logic [6:0] code;
        logic [3:0] hi_bits;
        logic [7:0] b;
        int         i;
        code = (form == FORM_SHORT) ? plen[6:0] : (form == FORM_MID) ? LEN_EXT16 : LEN_EXT64;
        // FIN, RSV and MASK bits are don't-care: randomize them
        hi_bits = 4'($urandom_range(0, 15));
        send_rx_byte({hi_bits, OPC_TEXT});
        b = 8'($urandom_range(0, 255));
        send_rx_byte({b[7], code});
        if (form == FORM_MID)
        begin
            send_rx_byte(plen[15:8]);
            send_rx_byte(plen[7:0]);
        end
        else if (form == FORM_LONG)
        begin
            repeat (4) send_rx_byte(8'h00);
            send_rx_byte(plen[31:24]);
            send_rx_byte(plen[23:16]);
            send_rx_byte(plen[15:8]);
            send_rx_byte(plen[7:0]);
        end
        send_rx_byte(key[31:24]);
        send_rx_byte(key[23:16]);
        send_rx_byte(key[15:8]);
        send_rx_byte(key[7:0]);
        for (i = 0; i < plen; i++)
        begin
            if (extremes)
                b = i[0] ? 8'hFF : 8'h00;
            else
                b = 8'($urandom_range(0, 255));
            send_rx_byte(b);
        end
    endtask

    task automatic send_random_frame();
        int unsigned plen;
        int          r;
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 16);
            send_text_frame(plen, FORM_SHORT, $urandom, 1'b0);
        end
        else
        begin
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40);
            send_text_frame(plen, (r < 9) ? FORM_MID : FORM_LONG, $urandom, 1'b0);
        end
    endtask

    task automatic test_directed_frames();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        send_text_frame(3, FORM_SHORT, 32'hFFFF_FFFF, 1'b1);
        send_text_frame(0, FORM_SHORT, 32'h0000_0000, 1'b0);
        send_text_frame(0, FORM_MID, $urandom, 1'b0);
        send_text_frame(1, FORM_LONG, 32'h0000_0000, 1'b1);
        wait_events_drained();
    endtask

    task automatic test_random_frames();
        int start;
        int frames;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        start  = bytes_sent;
        frames = 0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            send_random_frame();
            frames++;
            if (frames % 40 == 0)
                wait_events_drained();
        end
        wait_events_drained();
    endtask

    task automatic test_back_to_back();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        send_text_frame(125, FORM_SHORT, $urandom, 1'b0);
        send_text_frame(260, FORM_MID, $urandom, 1'b0);
        repeat (6) send_random_frame();
        wait_events_drained();
    endtask

    task automatic test_output_holdoff();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        hold_left   = HOLDOFF_CYC;
        // sender keeps pushing; block must fill and stall its input
        send_text_frame(60, FORM_SHORT, $urandom, 1'b0);
        send_text_frame(5, FORM_MID, $urandom, 1'b0);
        wait_events_drained();
    endtask

    task automatic test_halt_event();
        logic [3:0] opc;
        logic [3:0] hi_bits;
        logic [7:0] b;
        int         sel;
        int         nz_pos;
        int         i;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        sel     = $urandom_range(0, 2);
        hi_bits = 4'($urandom_range(0, 15));
        b       = 8'($urandom_range(0, 255));
        if (sel == 0)
        begin
            send_rx_byte({hi_bits, OPC_CLOSE});
            send_rx_byte(b);
        end
        else if (sel == 1)
        begin
            do
                opc = 4'($urandom_range(0, 15));
            while (opc == OPC_TEXT || opc == OPC_CLOSE);
            send_rx_byte({hi_bits, opc});
            send_rx_byte(b);
        end
        else
        begin
            send_rx_byte({hi_bits, OPC_TEXT});
            send_rx_byte({b[7], LEN_EXT64});
            nz_pos = $urandom_range(0, 3);
            for (i = 0; i < 4; i++)
                send_rx_byte((i == nz_pos) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255)));
            repeat (8) send_rx_byte(8'($urandom_range(0, 255)));
        end
        // halted: everything from here on is dropped
        repeat (12) send_rx_byte(8'($urandom_range(0, 255)));
        wait_events_drained();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        m_axis_tready <= 1'b0;
        frm_phase     = PH_HEADER;
        frm_hdr_cnt   = 4'd0;
        frm_opcode    = 4'd0;
        frm_len_code  = 7'd0;
        frm_upper_nz  = 1'b0;
        frm_remain    = 32'd0;
        frm_key       = 32'd0;
        frm_key_idx   = 2'd0;
        fail_cnt      = 0;
        cycle_cnt     = 0;
        bytes_sent    = 0;
        src_idle_en   = 1'b0;
        snk_idle_en   = 1'b0;
        snk_wait      = 0;
        hold_left     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_random_frames();
        test_back_to_back();
        test_output_holdoff();
        test_halt_event();

        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/wsd_pkg.sv
design/wsd_parser.sv
design/wsd_out_stage.sv
design/websocket_frame_deframer.sv
design/wsd_checker.sv
verif/tb.sv
